// ----- rtl/ops_pkg.sv -----
`default_nettype none

package ops_pkg;

  // Field widths.
  localparam int unsigned FRACT_W     = 32;
  localparam int unsigned COEFF_W     = 31;
  localparam int unsigned SNAP_W      = 16;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_COEFFICIENT    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SNAP_THRESHOLD = 8'd1;

  // Operation codes carried in the input tuser.
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Reset value of the snap threshold.
  localparam logic [SNAP_W-1:0] SNAP_RESET = 16'h0007;

  // Ends of the signed 1.31 range.
  localparam logic signed [FRACT_W-1:0] FRACT_MAX = 32'sh7fff_ffff;
  localparam logic signed [FRACT_W-1:0] FRACT_MIN = 32'sh8000_0000;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [COEFF_W-1:0] coefficient;
    logic [SNAP_W-1:0]  snap_threshold;
  } cfg_t;

  // Outcome of one filter step.
  typedef struct packed {
    logic signed [FRACT_W-1:0] level;
    logic                      sync;
  } step_t;

  // Clamp a 33-bit sum or difference to the signed 32-bit range.
  function automatic logic signed [FRACT_W-1:0] sat32(input logic signed [FRACT_W:0] v);
    logic signed [FRACT_W-1:0] r;
    if (v[FRACT_W] != v[FRACT_W-1]) begin
      r = v[FRACT_W] ? FRACT_MIN : FRACT_MAX;
    end else begin
      r = v[FRACT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/one_pole_smoother_fract32.sv -----
`default_nettype none

// Channel   Direction  Handshake                       Contents
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: target_value; tuser: op
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: smoothed; tuser: in_sync
// cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// An item is registered on acceptance; a set item is processed in the next cycle,
// and a tick result is registered once the output is free. One item per cycle while
// no tick waits; subtract, 32x31 multiply, add and snap compare are combinational.
// Reset clears the state to target 0, output 0, in sync, and empties both registers.
// A stalled output holds its result; set items still pass while the output is full,
// and a tick waits in the input register until the output register frees.

module one_pole_smoother_fract32 (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic signed [ops_pkg::FRACT_W-1:0]    s_axis_tdata,  // [31:0] target_value
  input  wire logic [0:0]                            s_axis_tuser,  // [0] op
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic signed [ops_pkg::FRACT_W-1:0]         m_axis_tdata,  // [31:0] smoothed
  output logic [0:0]                                 m_axis_tuser,  // [0] in_sync
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [ops_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [ops_pkg::CFG_DATA_W-1:0]        cfg_data
);

  ops_pkg::cfg_t                      cfg;
  ops_pkg::step_t                     step;
  logic                               in_valid;
  logic                               in_op;
  logic signed [ops_pkg::FRACT_W-1:0] in_target;
  logic signed [ops_pkg::FRACT_W-1:0] target;
  logic signed [ops_pkg::FRACT_W-1:0] output_level;
  logic                               sync_flag;
  logic                               out_free;
  logic                               fire;

  // Configuration registers.
  ops_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Filter step arithmetic.
  ops_step u_step (
    .cfg    (cfg),
    .target (target),
    .level  (output_level),
    .step   (step)
  );

  // A set item always proceeds; a tick needs room in the output register.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && ((in_op == ops_pkg::OP_SET) || out_free);
  assign s_axis_tready = !in_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_op     <= s_axis_tuser[0];
      in_target <= s_axis_tdata;
    end
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      target       <= '0;
      output_level <= '0;
      sync_flag    <= 1'b1;
    end else if (fire) begin
      if (in_op == ops_pkg::OP_SET) begin
        target    <= in_target;
        sync_flag <= (in_target == output_level);
      end else if (!sync_flag) begin
        output_level <= step.level;
        sync_flag    <= step.sync;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && (in_op == ops_pkg::OP_TICK)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (fire && (in_op == ops_pkg::OP_TICK)) begin
      m_axis_tdata    <= sync_flag ? output_level : step.level;
      m_axis_tuser[0] <= sync_flag ? 1'b1 : step.sync;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ops_cfg.sv -----
`default_nettype none

module ops_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ops_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ops_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ops_pkg::cfg_t                         cfg
);

  logic [ops_pkg::COEFF_W-1:0] coefficient;
  logic [ops_pkg::SNAP_W-1:0]  snap_threshold;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped and upper data bits ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      coefficient    <= '0;
      snap_threshold <= ops_pkg::SNAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ops_pkg::CFG_COEFFICIENT: begin
          coefficient <= cfg_data[ops_pkg::COEFF_W-1:0];
        end
        ops_pkg::CFG_SNAP_THRESHOLD: begin
          snap_threshold <= cfg_data[ops_pkg::SNAP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.coefficient    = coefficient;
  assign cfg.snap_threshold = snap_threshold;

endmodule

`default_nettype wire

// ----- rtl/ops_step.sv -----
`default_nettype none

module ops_step (
  input  ops_pkg::cfg_t                            cfg,
  input  wire logic signed [ops_pkg::FRACT_W-1:0]  target,
  input  wire logic signed [ops_pkg::FRACT_W-1:0]  level,
  output ops_pkg::step_t                           step
);

  logic signed [ops_pkg::FRACT_W:0]     diff_wide;
  logic signed [ops_pkg::FRACT_W-1:0]   diff;
  logic signed [ops_pkg::FRACT_W-1:0]   coeff_s;
  logic signed [2*ops_pkg::FRACT_W-1:0] product;
  logic signed [ops_pkg::FRACT_W-1:0]   scaled;
  logic signed [ops_pkg::FRACT_W:0]     sum_wide;
  logic signed [ops_pkg::FRACT_W-1:0]   new_level;
  logic signed [ops_pkg::FRACT_W:0]     back_wide;
  logic signed [ops_pkg::FRACT_W-1:0]   back;
  logic signed [ops_pkg::FRACT_W-1:0]   back_neg;
  logic [ops_pkg::FRACT_W-2:0]          magnitude;
  logic                                 snap;

  // Distance from the target, saturated.
  assign diff_wide = {level[ops_pkg::FRACT_W-1], level} - {target[ops_pkg::FRACT_W-1], target};
  assign diff      = ops_pkg::sat32(diff_wide);

  // Fractional product. The coefficient is below one, so the floor of the
  // product over 2^31 always fits in 32 bits and needs no clamp.
  assign coeff_s = $signed({1'b0, cfg.coefficient});
  assign product = (2*ops_pkg::FRACT_W)'(coeff_s) * (2*ops_pkg::FRACT_W)'(diff);
  assign scaled  = product[2*ops_pkg::FRACT_W-2:ops_pkg::FRACT_W-1];

  // New level is the target plus the shrunken distance.
  assign sum_wide  = {target[ops_pkg::FRACT_W-1], target} +
                     {scaled[ops_pkg::FRACT_W-1], scaled};
  assign new_level = ops_pkg::sat32(sum_wide);

  // Saturated absolute distance after the step; the most negative value maps to the maximum.
  assign back_wide = {target[ops_pkg::FRACT_W-1], target} -
                     {new_level[ops_pkg::FRACT_W-1], new_level};
  assign back      = ops_pkg::sat32(back_wide);
  assign back_neg  = -back;

  always_comb begin
    if (back == ops_pkg::FRACT_MIN) begin
      magnitude = ops_pkg::FRACT_MAX[ops_pkg::FRACT_W-2:0];
    end else if (back[ops_pkg::FRACT_W-1]) begin
      magnitude = back_neg[ops_pkg::FRACT_W-2:0];
    end else begin
      magnitude = back[ops_pkg::FRACT_W-2:0];
    end
  end

  assign snap = magnitude <= {{(ops_pkg::FRACT_W-1-ops_pkg::SNAP_W){1'b0}}, cfg.snap_threshold};

  // Close enough: land exactly on the target.
  assign step.level = snap ? target : new_level;
  assign step.sync  = snap;

endmodule

`default_nettype wire

// ----- rtl/ops_checker.sv -----
`default_nettype none

module ops_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [ops_pkg::FRACT_W-1:0]       m_axis_tdata,
  input wire logic [0:0]                        m_axis_tuser
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its item.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The input side only backs up when the output side is full and stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output could drain");

  // A fresh result comes from an accepted item via the input and result registers.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input item");

endmodule

bind one_pole_smoother_fract32 ops_checker u_ops_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- sim/one_pole_smoother_fract32_tb.sv -----
`default_nettype none

module one_pole_smoother_fract32_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 160;

  // Indexes that map to no register.
  localparam logic [ops_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 8'd2;
  localparam logic [ops_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 8'hff;

  localparam logic [ops_pkg::COEFF_W-1:0] COEFF_MAX  = '1;
  localparam logic [ops_pkg::COEFF_W-1:0] COEFF_HALF = 31'h4000_0000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an item or a register write.
  typedef struct {
    row_kind_t                          kind;
    logic                               op;
    logic signed [ops_pkg::FRACT_W-1:0] value;
    logic [ops_pkg::CFG_INDEX_W-1:0]    index;
    logic [ops_pkg::CFG_DATA_W-1:0]     data;
    bit                                 known;
    ops_pkg::step_t                     result;
  } stim_row_t;

  logic                               clk           = 1'b0;
  logic                               rst           = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic signed [ops_pkg::FRACT_W-1:0] s_axis_tdata  = '0;              // [31:0] target_value
  logic [0:0]                         s_axis_tuser  = ops_pkg::OP_SET; // [0] op
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic signed [ops_pkg::FRACT_W-1:0] m_axis_tdata;                    // [31:0] smoothed
  logic [0:0]                         m_axis_tuser;                    // [0] in_sync
  logic                               cfg_valid     = 1'b0;
  logic                               cfg_ready;
  logic [ops_pkg::CFG_INDEX_W-1:0]    cfg_index     = ops_pkg::CFG_COEFFICIENT;
  logic [ops_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;

  // Predicted state of the smoother and its registers.
  logic [ops_pkg::COEFF_W-1:0]        coeff_q  = '0;
  logic [ops_pkg::SNAP_W-1:0]         snap_q   = ops_pkg::SNAP_RESET;
  logic signed [ops_pkg::FRACT_W-1:0] target_q = '0;
  logic signed [ops_pkg::FRACT_W-1:0] level_q  = '0;
  logic                               sync_q   = 1'b1;
  ops_pkg::step_t                     pending_results[$];

  int errors      = 0;
  int items_in    = 0;
  int results_out = 0;
  int synced_out  = 0;
  int cfg_writes  = 0;
  int idle_cycles = 0;
  bit idle_enable = 1'b1;
  bit sender_gaps = 1'b1;
  bit hold_req    = 1'b0;

  one_pole_smoother_fract32 dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clamp a wide value to the signed 1.31 range.
  function automatic logic signed [ops_pkg::FRACT_W-1:0] fit32(input longint v);
    if (v > longint'(ops_pkg::FRACT_MAX)) return ops_pkg::FRACT_MAX;
    if (v < longint'(ops_pkg::FRACT_MIN)) return ops_pkg::FRACT_MIN;
    return v[ops_pkg::FRACT_W-1:0];
  endfunction

  // Fractional multiply, floored after the shift by 31.
  function automatic logic signed [ops_pkg::FRACT_W-1:0] frac_mul(
      input logic [ops_pkg::COEFF_W-1:0] c, input logic signed [ops_pkg::FRACT_W-1:0] d);
    longint prod;
    prod = longint'(c) * longint'(d);
    return fit32(prod >>> 31);
  endfunction

  // Advance the predicted smoother by one item; returns 1 when a result follows.
  function automatic bit glide_step(input logic op,
                                    input logic signed [ops_pkg::FRACT_W-1:0] value,
                                    output ops_pkg::step_t res);
    logic signed [ops_pkg::FRACT_W-1:0] diff;
    longint                             gap;
    res = '0;
    if (op == ops_pkg::OP_SET) begin
      target_q = value;
      sync_q   = (value == level_q);
      return 1'b0;
    end
    if (!sync_q) begin
      diff    = fit32(longint'(level_q) - longint'(target_q));
      level_q = fit32(longint'(target_q) + longint'(frac_mul(coeff_q, diff)));
      gap     = longint'(fit32(longint'(target_q) - longint'(level_q)));
      if (gap < 0) gap = -gap;
      if (gap > longint'(ops_pkg::FRACT_MAX)) gap = longint'(ops_pkg::FRACT_MAX);
      if (gap <= longint'(snap_q)) begin
        level_q = target_q;
        sync_q  = 1'b1;
      end
    end
    res.level = level_q;
    res.sync  = sync_q;
    return 1'b1;
  endfunction

  // Targets lean towards extremes and towards values within snap reach of the output.
  function automatic logic signed [ops_pkg::FRACT_W-1:0] pick_target();
    longint delta;
    delta = longint'($urandom_range(0, int'(snap_q) * 2 + 6)) - longint'(snap_q) - 3;
    case ($urandom_range(0, 9))
      0:       return ops_pkg::FRACT_MAX;
      1:       return ops_pkg::FRACT_MIN;
      2:       return '0;
      3:       return '1;
      4, 5:    return fit32(longint'(level_q) + delta);
      6:       return level_q;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t item_row(input logic op_i,
                                         input logic signed [ops_pkg::FRACT_W-1:0] v);
    stim_row_t r;
    r = '{kind: ROW_ITEM, op: op_i, value: v, index: '0, data: '0, known: 1'b0, result: '0};
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic op_i,
                                          input logic signed [ops_pkg::FRACT_W-1:0] v,
                                          input logic signed [ops_pkg::FRACT_W-1:0] lvl,
                                          input logic s);
    stim_row_t r;
    r = item_row(op_i, v);
    r.known  = 1'b1;
    r.result = '{level: lvl, sync: s};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [ops_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [ops_pkg::CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '{kind: ROW_CFG, op: ops_pkg::OP_SET, value: '0, index: idx, data: d, known: 1'b0,
          result: '0};
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Offer one item, wait for it to be taken, and record what it should produce.
  task automatic send_item(input logic op, input logic signed [ops_pkg::FRACT_W-1:0] value,
                           input bit known, input ops_pkg::step_t typed);
    ops_pkg::step_t res;
    if (idle_enable && sender_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    items_in++;
    if (glide_step(op, value, res)) pending_results.push_back(known ? typed : res);
  endtask

  // Let every result drain, then give the pipeline time to finish any set item.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ops_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ops_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      ops_pkg::CFG_COEFFICIENT:    coeff_q = d[ops_pkg::COEFF_W-1:0];
      ops_pkg::CFG_SNAP_THRESHOLD: snap_q  = d[ops_pkg::SNAP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [ops_pkg::CFG_DATA_W-1:0] coeff_d,
                           input logic [ops_pkg::CFG_DATA_W-1:0] snap_d);
    wait_idle();
    write_reg(ops_pkg::CFG_COEFFICIENT, coeff_d);
    write_reg(ops_pkg::CFG_SNAP_THRESHOLD, snap_d);
  endtask

  // Mostly a new target followed by a run of ticks; now and then a stray item.
  task automatic run_phase(input int n_items, input bit tick_heavy);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
        sent++;
      end else begin
        send_item(ops_pkg::OP_SET, pick_target(), 1'b0, '0);
        run_len = tick_heavy ? $urandom_range(8, 40) : $urandom_range(1, 12);
        repeat (run_len) send_item(ops_pkg::OP_TICK, $urandom, 1'b0, '0);
        sent += run_len + 1;
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        stall = 0;
        while (stall < HOLD_CYCLES) begin
          @(posedge clk);
          stall++;
        end
        hold_req = 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result with the oldest prediction; also track stretches with no traffic.
  always @(negedge clk) begin
    ops_pkg::step_t want;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result %h/%b with nothing predicted", m_axis_tdata,
                               m_axis_tuser));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata !== want.level)
            flag_error($sformatf("result %0d: smoothed %h, predicted %h", results_out,
                                 m_axis_tdata, want.level));
          if (m_axis_tuser[0] !== want.sync)
            flag_error($sformatf("result %0d: in_sync %b, predicted %b", results_out,
                                 m_axis_tuser[0], want.sync));
          if (want.sync) synced_out++;
        end
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t rows[$];

    // After reset the output is 0 and in sync; with coefficient 0 a tick jumps to the target.
    rows.push_back(known_row(ops_pkg::OP_TICK, $urandom, '0, 1'b1));
    rows.push_back(item_row(ops_pkg::OP_SET, '0));
    rows.push_back(known_row(ops_pkg::OP_TICK, $urandom, '0, 1'b1));
    rows.push_back(item_row(ops_pkg::OP_SET, ops_pkg::FRACT_MAX));
    rows.push_back(known_row(ops_pkg::OP_TICK, $urandom, ops_pkg::FRACT_MAX, 1'b1));
    rows.push_back(known_row(ops_pkg::OP_TICK, $urandom, ops_pkg::FRACT_MAX, 1'b1));
    rows.push_back(item_row(ops_pkg::OP_SET, ops_pkg::FRACT_MIN));
    rows.push_back(known_row(ops_pkg::OP_TICK, $urandom, ops_pkg::FRACT_MIN, 1'b1));
    // Bits above the coefficient register's width must be dropped.
    rows.push_back(cfg_row(ops_pkg::CFG_COEFFICIENT, 32'hffff_ffff));
    rows.push_back(cfg_row(ops_pkg::CFG_SNAP_THRESHOLD, 32'h0000_0000));
    rows.push_back(item_row(ops_pkg::OP_SET, ops_pkg::FRACT_MAX));
    rows.push_back(item_row(ops_pkg::OP_TICK, $urandom));
    rows.push_back(item_row(ops_pkg::OP_TICK, $urandom));
    // Writes to unmapped indexes must change nothing.
    rows.push_back(cfg_row(CFG_UNMAPPED_LO, 32'h0000_0000));
    rows.push_back(cfg_row(CFG_UNMAPPED_HI, 32'hffff_ffff));
    rows.push_back(item_row(ops_pkg::OP_TICK, $urandom));
    rows.push_back(cfg_row(ops_pkg::CFG_SNAP_THRESHOLD, 32'hffff_ffff));
    rows.push_back(item_row(ops_pkg::OP_SET, '1));
    rows.push_back(item_row(ops_pkg::OP_TICK, $urandom));
    rows.push_back(item_row(ops_pkg::OP_SET, ops_pkg::FRACT_MIN));
    rows.push_back(item_row(ops_pkg::OP_TICK, $urandom));
    rows.push_back(cfg_row(ops_pkg::CFG_COEFFICIENT, {1'b0, COEFF_HALF}));
    rows.push_back(item_row(ops_pkg::OP_SET, 32'sh0001_2345));
    rows.push_back(item_row(ops_pkg::OP_TICK, $urandom));
    rows.push_back(item_row(ops_pkg::OP_TICK, $urandom));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(rows[i].index, rows[i].data);
      end else begin
        send_item(rows[i].op, rows[i].value, rows[i].known, rows[i].result);
      end
    end

    // Random phases over a spread of settings, extremes first.
    configure(32'h0000_0000, 32'h0000_0000);
    run_phase(PHASE_ITEMS, 1'b0);
    configure({1'($urandom_range(0, 1)), COEFF_MAX}, {16'($urandom), 16'hffff});
    run_phase(PHASE_ITEMS, 1'b0);
    configure($urandom, $urandom);
    run_phase(PHASE_ITEMS, 1'b0);
    configure({1'b0, COEFF_HALF}, 32'(ops_pkg::SNAP_RESET));
    run_phase(PHASE_ITEMS, 1'b0);
    configure($urandom_range(0, 32'h0fff_ffff), $urandom_range(0, 64));
    run_phase(PHASE_ITEMS, 1'b0);

    // Back-pressure: the sink holds off while ticks keep coming without gaps.
    configure($urandom, $urandom_range(0, 255));
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    run_phase(PHASE_ITEMS, 1'b1);
    sender_gaps = 1'b1;

    // Last stretch runs at full rate on both sides.
    configure($urandom, $urandom);
    idle_enable = 1'b0;
    run_phase(PHASE_ITEMS, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Ran %0d items for %0d results (%0d in sync) and %0d register writes,",
             items_in, results_out, synced_out, cfg_writes);
    $display("through extreme, random, stalled and full-rate settings; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- one_pole_smoother_fract32.f -----
rtl/ops_pkg.sv
rtl/ops_cfg.sv
rtl/ops_step.sv
rtl/one_pole_smoother_fract32.sv
rtl/ops_checker.sv
sim/one_pole_smoother_fract32_tb.sv
